/* rtl/api_pkg.sv */
// ----------------------------------------------------------------------------
// api_pkg - shared types and constants of the pose integrator
// payload words, microcode word layout, program table and arctangent table
// ----------------------------------------------------------------------------
package api_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CW               = 34;   // cordic datapath width
    localparam int UC_AW            = 5;    // microcode address width

    localparam logic [15:0]        WB_RESET        = 16'd512;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [31:0] RAD_TO_BAM      = 32'sd683565276;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] speed;
        logic signed [15:0] turn_rate;
        logic [15:0]        elapsed;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [15:0] steer_angle;
    } t_out_item;

    // datapath operations
    typedef enum logic [3:0] {
        U_NOP,
        U_HOLD,
        U_VEC_INIT,
        U_VEC_STEP,
        U_STEER,
        U_ROT_INIT,
        U_CAP_VDT,
        U_CAP_WDT,
        U_ROT_STEP,
        U_ROT_FLIP,
        U_ADD_X,
        U_ADD_Y,
        U_ADD_H,
        U_EMIT
    } t_uop;

    // multiplier operand selection
    typedef enum logic [2:0] {
        M_NONE,
        M_WB_W,
        M_V_DT,
        M_W_DT,
        M_T_C,
        M_T_S,
        M_U_K
    } t_msel;

    // sequencing
    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_IF,
        SEQ_LOOP,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT
    } t_seq;

    typedef enum logic [1:0] {
        C_NONE,
        C_TICK,
        C_VW_ZERO,
        C_DT_ZERO
    } t_cond;

    typedef struct packed {
        t_uop             uop;
        t_msel            msel;
        t_seq             seq;
        t_cond            cond;
        logic [UC_AW-1:0] target;
    } t_uword;

    // program addresses
    localparam logic [UC_AW-1:0] ST_FETCH    = 5'd0;
    localparam logic [UC_AW-1:0] ST_DISP     = 5'd1;
    localparam logic [UC_AW-1:0] ST_HOLD     = 5'd2;
    localparam logic [UC_AW-1:0] ST_MUL_WBW  = 5'd3;
    localparam logic [UC_AW-1:0] ST_VEC_INIT = 5'd4;
    localparam logic [UC_AW-1:0] ST_VEC_LOOP = 5'd5;
    localparam logic [UC_AW-1:0] ST_STEER    = 5'd6;
    localparam logic [UC_AW-1:0] ST_TICK     = 5'd7;
    localparam logic [UC_AW-1:0] ST_ROT_INIT = 5'd8;
    localparam logic [UC_AW-1:0] ST_CAP_VDT  = 5'd9;
    localparam logic [UC_AW-1:0] ST_CAP_WDT  = 5'd10;
    localparam logic [UC_AW-1:0] ST_ROT_LOOP = 5'd11;
    localparam logic [UC_AW-1:0] ST_ROT_FLIP = 5'd12;
    localparam logic [UC_AW-1:0] ST_MUL_C    = 5'd13;
    localparam logic [UC_AW-1:0] ST_ADD_X    = 5'd14;
    localparam logic [UC_AW-1:0] ST_ADD_Y    = 5'd15;
    localparam logic [UC_AW-1:0] ST_ADD_H    = 5'd16;
    localparam logic [UC_AW-1:0] ST_EMIT     = 5'd17;

    function automatic t_uword uc_rom(input logic [UC_AW-1:0] addr);
        t_uword w;
        w = '{uop: U_NOP, msel: M_NONE, seq: SEQ_GOTO, cond: C_NONE, target: ST_FETCH};
        case (addr)
            ST_FETCH:    w = '{U_NOP,      M_NONE, SEQ_WAIT_IN,  C_NONE,    ST_FETCH};
            ST_DISP:     w = '{U_NOP,      M_NONE, SEQ_IF,       C_TICK,    ST_TICK};
            ST_HOLD:     w = '{U_HOLD,     M_NONE, SEQ_IF,       C_VW_ZERO, ST_FETCH};
            ST_MUL_WBW:  w = '{U_NOP,      M_WB_W, SEQ_NEXT,     C_NONE,    ST_FETCH};
            ST_VEC_INIT: w = '{U_VEC_INIT, M_NONE, SEQ_NEXT,     C_NONE,    ST_FETCH};
            ST_VEC_LOOP: w = '{U_VEC_STEP, M_NONE, SEQ_LOOP,     C_NONE,    ST_FETCH};
            ST_STEER:    w = '{U_STEER,    M_NONE, SEQ_GOTO,     C_NONE,    ST_FETCH};
            ST_TICK:     w = '{U_NOP,      M_NONE, SEQ_IF,       C_DT_ZERO, ST_FETCH};
            ST_ROT_INIT: w = '{U_ROT_INIT, M_V_DT, SEQ_NEXT,     C_NONE,    ST_FETCH};
            ST_CAP_VDT:  w = '{U_CAP_VDT,  M_W_DT, SEQ_NEXT,     C_NONE,    ST_FETCH};
            ST_CAP_WDT:  w = '{U_CAP_WDT,  M_NONE, SEQ_NEXT,     C_NONE,    ST_FETCH};
            ST_ROT_LOOP: w = '{U_ROT_STEP, M_NONE, SEQ_LOOP,     C_NONE,    ST_FETCH};
            ST_ROT_FLIP: w = '{U_ROT_FLIP, M_NONE, SEQ_NEXT,     C_NONE,    ST_FETCH};
            ST_MUL_C:    w = '{U_NOP,      M_T_C,  SEQ_NEXT,     C_NONE,    ST_FETCH};
            ST_ADD_X:    w = '{U_ADD_X,    M_T_S,  SEQ_NEXT,     C_NONE,    ST_FETCH};
            ST_ADD_Y:    w = '{U_ADD_Y,    M_U_K,  SEQ_NEXT,     C_NONE,    ST_FETCH};
            ST_ADD_H:    w = '{U_ADD_H,    M_NONE, SEQ_NEXT,     C_NONE,    ST_FETCH};
            ST_EMIT:     w = '{U_EMIT,     M_NONE, SEQ_WAIT_OUT, C_NONE,    ST_FETCH};
            default:     w = '{U_NOP,      M_NONE, SEQ_GOTO,     C_NONE,    ST_FETCH};
        endcase
        return w;
    endfunction

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [CW-1:0] a;
        a = '0;
        case (idx)
            5'd0:    a = 34'sd536870912;
            5'd1:    a = 34'sd316933406;
            5'd2:    a = 34'sd167458907;
            5'd3:    a = 34'sd85004756;
            5'd4:    a = 34'sd42667331;
            5'd5:    a = 34'sd21354465;
            5'd6:    a = 34'sd10679838;
            5'd7:    a = 34'sd5340245;
            5'd8:    a = 34'sd2670163;
            5'd9:    a = 34'sd1335087;
            5'd10:   a = 34'sd667544;
            5'd11:   a = 34'sd333772;
            5'd12:   a = 34'sd166886;
            5'd13:   a = 34'sd83443;
            5'd14:   a = 34'sd41722;
            5'd15:   a = 34'sd20861;
            5'd16:   a = 34'sd10430;
            5'd17:   a = 34'sd5215;
            5'd18:   a = 34'sd2608;
            5'd19:   a = 34'sd1304;
            5'd20:   a = 34'sd652;
            5'd21:   a = 34'sd326;
            5'd22:   a = 34'sd163;
            5'd23:   a = 34'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/ackermann_pose_integrator.sv */
// ----------------------------------------------------------------------------
// ackermann_pose_integrator - dead-reckoning pose of a car-like vehicle
// microcoded sequencer over a shared cordic stage and one 32x32 multiplier
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready / i_in_item): one word per item.
//   a command word latches speed and turn rate and recomputes the steering
//   angle; it gives no output word. a tick word with nonzero elapsed time
//   advances the pose and gives one output word (o_out_valid / i_out_ready /
//   o_out_item). a tick with zero elapsed time changes nothing.
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_axle_span) writes the
//   wheel base; it is always ready. the user must write it only while the
//   block idles; the block itself does not enforce this. flow: one item at
//   a time. a command with zero speed or turn rate and a zero tick return
//   to fetch after dispatch; any other command runs the vectoring cordic
//   loop and the steering step, a nonzero tick the rotation cordic loop,
//   the multiply and add steps and the emit step. the output register parts
//   the two sides: the next item is taken while a result waits; a new result
//   waits at the emit step while the receiver stalls the previous one.
//   reset: pose, held command and steering cleared, wheel base 2.0 m.
// ----------------------------------------------------------------------------
module ackermann_pose_integrator #(
    parameter int CORDIC_STEPS = api_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  api_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output api_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_axle_span
);
    import api_pkg::*;

    localparam int ITW = $clog2(CORDIC_STEPS);
    localparam logic [ITW-1:0] LAST_ITER = ITW'(CORDIC_STEPS - 1);

    // control and architectural state
    logic [UC_AW-1:0]   r_step, n_step;
    logic [ITW-1:0]     r_iter, n_iter;
    logic [15:0]        r_wb;
    logic signed [15:0] r_speed, n_speed;
    logic signed [15:0] r_turn, n_turn;
    logic signed [15:0] r_steer, n_steer;
    logic signed [31:0] r_posx, n_posx;
    logic signed [31:0] r_posy, n_posy;
    logic [15:0]        r_heading, n_heading;
    logic               r_out_valid, n_out_valid;

    // datapath
    t_in_item           r_item;
    t_out_item          r_out, n_out;
    logic signed [CW-1:0] r_x, n_x;
    logic signed [CW-1:0] r_y, n_y;
    logic signed [CW-1:0] r_z, n_z;
    logic               r_flip, n_flip;
    logic signed [63:0] r_prod, n_prod;
    logic signed [31:0] r_vdt, n_vdt;
    logic signed [31:0] r_wdt, n_wdt;

    t_uword             uw;
    logic               in_acc;
    logic               out_free;
    logic               cond_ok;
    logic signed [31:0] mul_a, mul_b;
    logic signed [CW-1:0] dx, dy, ang;
    logic signed [CW-1:0] spd_sh, prod34;
    logic signed [17:0] h18, hfold;
    logic signed [63:0] prod_rnd, disp;
    logic signed [CW-1:0] disp34, sum_x, sum_y, zrnd;

    assign uw          = uc_rom(r_step);
    assign o_in_ready  = (r_step == ST_FETCH);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        case (uw.cond)
            C_TICK:    cond_ok = r_item.kind;
            C_VW_ZERO: cond_ok = (r_item.speed == 16'sd0) || (r_item.turn_rate == 16'sd0);
            C_DT_ZERO: cond_ok = (r_item.elapsed == 16'd0);
            default:   cond_ok = 1'b0;
        endcase
    end

    // step counter
    always_comb begin
        case (uw.seq)
            SEQ_NEXT:     n_step = r_step + 1'b1;
            SEQ_GOTO:     n_step = uw.target;
            SEQ_IF:       n_step = cond_ok ? uw.target : r_step + 1'b1;
            SEQ_LOOP:     n_step = (r_iter == LAST_ITER) ? r_step + 1'b1 : r_step;
            SEQ_WAIT_IN:  n_step = in_acc ? r_step + 1'b1 : r_step;
            SEQ_WAIT_OUT: n_step = out_free ? uw.target : r_step;
            default:      n_step = ST_FETCH;
        endcase
    end

    // shared multiplier, product registered
    always_comb begin
        case (uw.msel)
            M_WB_W: begin
                mul_a = {16'd0, r_wb};
                mul_b = 32'(r_turn);
            end
            M_V_DT: begin
                mul_a = 32'(r_speed);
                mul_b = {16'd0, r_item.elapsed};
            end
            M_W_DT: begin
                mul_a = 32'(r_turn);
                mul_b = {16'd0, r_item.elapsed};
            end
            M_T_C: begin
                mul_a = r_vdt;
                mul_b = r_x[31:0];
            end
            M_T_S: begin
                mul_a = r_vdt;
                mul_b = r_y[31:0];
            end
            M_U_K: begin
                mul_a = r_wdt;
                mul_b = RAD_TO_BAM;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = (uw.msel == M_NONE) ? r_prod : mul_a * mul_b;
    end

    // shared arithmetic terms
    always_comb begin
        dx       = r_y >>> r_iter;
        dy       = r_x >>> r_iter;
        ang      = atan_entry(5'(r_iter));
        spd_sh   = {{6{r_speed[15]}}, r_speed, 12'd0};
        prod34   = r_prod[CW-1:0];
        h18      = {{2{r_heading[15]}}, r_heading};
        // fold into the right half plane, negate the result afterwards
        if (h18 > 18'sd16384) begin
            hfold = h18 - 18'sd32768;
        end else if (h18 < -18'sd16384) begin
            hfold = h18 + 18'sd32768;
        end else begin
            hfold = h18;
        end
        prod_rnd = r_prod + (64'sd1 <<< 37);
        disp     = prod_rnd >>> 38;
        disp34   = disp[CW-1:0];
        sum_x    = {{2{r_posx[31]}}, r_posx} + disp34;
        sum_y    = {{2{r_posy[31]}}, r_posy} + disp34;
        zrnd     = (r_z + 34'sd32768) >>> 16;
    end

    always_comb begin
        n_iter      = r_iter;
        n_speed     = r_speed;
        n_turn      = r_turn;
        n_steer     = r_steer;
        n_posx      = r_posx;
        n_posy      = r_posy;
        n_heading   = r_heading;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_flip      = r_flip;
        n_vdt       = r_vdt;
        n_wdt       = r_wdt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (uw.uop)
            U_HOLD: begin
                n_speed = r_item.speed;
                n_turn  = r_item.turn_rate;
                n_steer = '0;
            end
            U_VEC_INIT: begin
                n_x    = r_speed[15] ? -spd_sh : spd_sh;
                n_y    = r_speed[15] ? -prod34 : prod34;
                n_z    = '0;
                n_iter = '0;
            end
            U_VEC_STEP: begin
                if (r_y > 34'sd0) begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + ang;
                end else begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - ang;
                end
                n_iter = r_iter + 1'b1;
            end
            U_STEER: begin
                if (zrnd > 34'sd16384) begin
                    n_steer = 16'sd16384;
                end else if (zrnd < -34'sd16384) begin
                    n_steer = -16'sd16384;
                end else begin
                    n_steer = zrnd[15:0];
                end
            end
            U_ROT_INIT: begin
                n_x    = CORDIC_GAIN_INV;
                n_y    = '0;
                n_z    = {hfold, 16'd0};
                n_flip = (hfold != h18);
                n_iter = '0;
            end
            U_CAP_VDT: n_vdt = r_prod[31:0];
            U_CAP_WDT: n_wdt = r_prod[31:0];
            U_ROT_STEP: begin
                if (r_z >= 34'sd0) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - ang;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + ang;
                end
                n_iter = r_iter + 1'b1;
            end
            U_ROT_FLIP: begin
                if (r_flip) begin
                    n_x = -r_x;
                    n_y = -r_y;
                end
            end
            U_ADD_X: begin
                if (sum_x > 34'sd2147483647) begin
                    n_posx = 32'sh7fffffff;
                end else if (sum_x < -34'sd2147483648) begin
                    n_posx = 32'sh80000000;
                end else begin
                    n_posx = sum_x[31:0];
                end
            end
            U_ADD_Y: begin
                if (sum_y > 34'sd2147483647) begin
                    n_posy = 32'sh7fffffff;
                end else if (sum_y < -34'sd2147483648) begin
                    n_posy = 32'sh80000000;
                end else begin
                    n_posy = sum_y[31:0];
                end
            end
            U_ADD_H: begin
                // round to whole binary-angle units, wrap modulo one turn
                n_heading = r_heading + 16'((r_prod + (64'sd1 <<< 43)) >>> 44);
            end
            U_EMIT: begin
                if (out_free) begin
                    n_out.pos_x       = r_posx;
                    n_out.pos_y       = r_posy;
                    n_out.heading     = r_heading;
                    n_out.steer_angle = r_steer;
                    n_out_valid       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_FETCH;
            r_iter      <= '0;
            r_wb        <= WB_RESET;
            r_speed     <= '0;
            r_turn      <= '0;
            r_steer     <= '0;
            r_posx      <= '0;
            r_posy      <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_iter      <= n_iter;
            r_speed     <= n_speed;
            r_turn      <= n_turn;
            r_steer     <= n_steer;
            r_posx      <= n_posx;
            r_posy      <= n_posy;
            r_heading   <= n_heading;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_wb <= i_cfg_axle_span;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_item;
        end
        r_out  <= n_out;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_flip <= n_flip;
        r_prod <= n_prod;
        r_vdt  <= n_vdt;
        r_wdt  <= n_wdt;
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= ST_EMIT)
        else $error("step counter left the program");

    a_zero_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.kind && (i_in_item.elapsed == 16'd0)) |-> ##3 o_in_ready)
        else $error("zero tick did not return to fetch");

    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_step) == ST_EMIT))
        else $error("output word raised outside the emit step");

    a_heading_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_heading) |-> ($past(r_step) == ST_ADD_H))
        else $error("heading changed outside its update step");

    a_steer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.steer_angle <= 16'sd16384)
                      && (o_out_item.steer_angle >= -16'sd16384)))
        else $error("steering angle out of range");
`endif

endmodule

/* tb/ackermann_pose_integrator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ackermann_pose_integrator_test - self-checking bench for the pose integrator
// a scoreboard class models the cordic datapath bit for bit and checks every
// output word; stimulus covers saturation, steering extremes, heading wrap,
// zero ticks and all wheel base extremes under varying handshake pressure
// ----------------------------------------------------------------------------
module ackermann_pose_integrator_test;
    import api_pkg::*;

    localparam int          ITER_COUNT    = 16;
    localparam logic [15:0] WB_POWER_UP   = 16'd512;
    localparam logic        KIND_COMMAND  = 1'b0;
    localparam logic        KIND_TICK     = 1'b1;
    localparam longint      GAIN_COMP     = 64'sd652032874;
    localparam longint      RAD_TO_ANGLE  = 64'sd683565276;
    localparam longint      POS_MAX       = 64'sd2147483647;
    localparam longint      POS_MIN       = -64'sd2147483648;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          STALL_LIMIT   = 3000;
    localparam int          PHASE_ITEMS   = 32;
    localparam int          LIMIT_TICKS   = 262;

    // ------------------------------------------------------------------------
    class pose_scoreboard;
        logic [15:0]        axle_span  = WB_POWER_UP;
        logic signed [31:0] x_pos      = '0;
        logic signed [31:0] y_pos      = '0;
        logic [15:0]        heading    = '0;
        logic signed [15:0] held_speed = '0;
        logic signed [15:0] held_turn  = '0;
        logic signed [15:0] held_steer = '0;
        t_out_item          pose_q[$];
        int                 fail_count = 0;

        // arctangent of 2^-k, 2^32 units per turn
        function longint atan_step(int k);
            case (k)
                0:       return 64'sd536870912;
                1:       return 64'sd316933406;
                2:       return 64'sd167458907;
                3:       return 64'sd85004756;
                4:       return 64'sd42667331;
                5:       return 64'sd21354465;
                6:       return 64'sd10679838;
                7:       return 64'sd5340245;
                8:       return 64'sd2670163;
                9:       return 64'sd1335087;
                10:      return 64'sd667544;
                11:      return 64'sd333772;
                12:      return 64'sd166886;
                13:      return 64'sd83443;
                14:      return 64'sd41722;
                15:      return 64'sd20861;
                16:      return 64'sd10430;
                17:      return 64'sd5215;
                18:      return 64'sd2608;
                19:      return 64'sd1304;
                20:      return 64'sd652;
                21:      return 64'sd326;
                22:      return 64'sd163;
                default: return 64'sd81;
            endcase
        endfunction

        // cos and sin of a binary angle, 30 fraction bits
        function void unit_vector(input logic [15:0] ang, output longint cv, output longint sv);
            logic signed [15:0] hs;
            longint             h, xv, yv, zv, dx, dy;
            bit                 flip;
            hs   = ang;
            h    = hs;
            flip = 1'b0;
            if (h > 16384) begin
                h    = h - 32768;
                flip = 1'b1;
            end else if (h < -16384) begin
                h    = h + 32768;
                flip = 1'b1;
            end
            xv = GAIN_COMP;
            yv = 0;
            zv = h * 65536;
            for (int k = 0; k < ITER_COUNT; k++) begin
                dx = yv >>> k;
                dy = xv >>> k;
                if (zv >= 0) begin
                    xv = xv - dx;
                    yv = yv + dy;
                    zv = zv - atan_step(k);
                end else begin
                    xv = xv + dx;
                    yv = yv - dy;
                    zv = zv + atan_step(k);
                end
            end
            if (flip) begin
                xv = -xv;
                yv = -yv;
            end
            cv = xv;
            sv = yv;
        endfunction

        // angle of (xin, yin) for xin > 0, 16384 per quarter turn
        function logic signed [15:0] vector_angle(longint xin, longint yin);
            longint xv, yv, zv, dx, dy, r;
            xv = xin;
            yv = yin;
            zv = 0;
            for (int k = 0; k < ITER_COUNT; k++) begin
                dx = yv >>> k;
                dy = xv >>> k;
                if (yv > 0) begin
                    xv = xv + dx;
                    yv = yv - dy;
                    zv = zv + atan_step(k);
                end else begin
                    xv = xv - dx;
                    yv = yv + dy;
                    zv = zv - atan_step(k);
                end
            end
            r = (zv + 32768) >>> 16;
            if (r > 16384)
                r = 16384;
            if (r < -16384)
                r = -16384;
            return r[15:0];
        endfunction

        function logic signed [31:0] clamp_add(logic signed [31:0] a, longint d);
            longint r;
            r = a;
            r = r + d;
            if (r > POS_MAX)
                r = POS_MAX;
            if (r < POS_MIN)
                r = POS_MIN;
            return r[31:0];
        endfunction

        function void set_axle_span(logic [15:0] value);
            axle_span = value;
        endfunction

        function void note_input(t_in_item it);
            longint    v, w, dt, wb, num, den, cv, sv, p;
            t_out_item pose;
            if (it.kind == KIND_COMMAND) begin
                v          = it.speed;
                w          = it.turn_rate;
                held_speed = it.speed;
                held_turn  = it.turn_rate;
                if (v == 0 || w == 0) begin
                    held_steer = '0;
                end else begin
                    wb  = axle_span;
                    num = wb * w;
                    den = v * 4096;
                    if (den < 0) begin
                        den = -den;
                        num = -num;
                    end
                    held_steer = vector_angle(den, num);
                end
                return;
            end
            dt = it.elapsed;
            if (dt == 0)
                return;
            v = held_speed;
            w = held_turn;
            unit_vector(heading, cv, sv);
            p       = v * cv * dt;
            x_pos   = clamp_add(x_pos, (p + (64'sd1 <<< 37)) >>> 38);
            p       = v * sv * dt;
            y_pos   = clamp_add(y_pos, (p + (64'sd1 <<< 37)) >>> 38);
            p       = w * dt * RAD_TO_ANGLE;
            p       = (p + (64'sd1 <<< 43)) >>> 44;
            heading = heading + p[15:0];
            pose.pos_x       = x_pos;
            pose.pos_y       = y_pos;
            pose.heading     = heading;
            pose.steer_angle = held_steer;
            pose_q.push_back(pose);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pose_q.size() == 0) begin
                $error("output word with no pose expected");
                fail_count++;
                return;
            end
            want = pose_q.pop_front();
            if (got.pos_x !== want.pos_x) begin
                $error("pos_x: expected %0d, actual %0d", want.pos_x, got.pos_x);
                fail_count++;
            end
            if (got.pos_y !== want.pos_y) begin
                $error("pos_y: expected %0d, actual %0d", want.pos_y, got.pos_y);
                fail_count++;
            end
            if (got.heading !== want.heading) begin
                $error("heading: expected %0d, actual %0d", want.heading, got.heading);
                fail_count++;
            end
            if (got.steer_angle !== want.steer_angle) begin
                $error("steer_angle: expected %0d, actual %0d",
                       want.steer_angle, got.steer_angle);
                fail_count++;
            end
        endfunction

        function int pending();
            return pose_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    t_in_item    in_item    = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_wb     = '0;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off_req  = 1'b0;
    int          quiet_cycles  = 0;

    pose_scoreboard sb = new;

    ackermann_pose_integrator #(
        .CORDIC_STEPS (ITER_COUNT)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_in_item        (in_item),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_out_item       (out_item),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_axle_span  (cfg_wb)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // sample every handshake at the rising edge
    always @(posedge clk) begin
        if (out_valid && out_ready)
            sb.check_result(out_item);
        if (in_valid && in_ready)
            sb.note_input(in_item);
        if (cfg_valid && cfg_ready)
            sb.set_axle_span(cfg_wb);
        if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, with one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end else begin
                out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_in_item command_word(logic [15:0] spd, logic [15:0] turn,
                                              logic [15:0] dt);
        t_in_item it;
        it.kind      = KIND_COMMAND;
        it.speed     = spd;
        it.turn_rate = turn;
        it.elapsed   = dt;
        return it;
    endfunction

    function automatic t_in_item tick_word(logic [15:0] dt);
        t_in_item it;
        it.kind      = KIND_TICK;
        it.speed     = 16'($urandom);
        it.turn_rate = 16'($urandom);
        it.elapsed   = dt;
        return it;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_elapsed();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(15, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(t_in_item it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge clk); while (!in_ready);
    endtask

    // drop valid, drain every pending pose, then let a trailing command finish
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_axle_span(logic [15:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_wb    = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one command followed by a short run of ticks, sometimes a stray command
    task automatic send_segment(output int count);
        int n;
        count = 0;
        send_word(command_word(pick_value(), pick_value(), 16'($urandom)));
        count++;
        if ($urandom_range(9) == 0) begin
            send_word(command_word(pick_value(), pick_value(), 16'($urandom)));
            count++;
        end
        n = $urandom_range(6, 1);
        repeat (n) begin
            send_word(tick_word(pick_elapsed()));
            count++;
        end
    endtask

    task automatic run_phase(logic [15:0] wb, int idle_pct, int stall_pct, bit squeeze);
        int sent;
        int seg;
        bit squeezed;
        drain();
        write_axle_span(wb);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent     = 0;
        squeezed = 1'b0;
        while (sent < PHASE_ITEMS) begin
            if (squeeze && !squeezed && sent >= 8) begin
                hold_off_req = 1'b1;
                squeezed     = 1'b1;
            end
            send_segment(seg);
            sent += seg;
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // straight run at full speed from the origin until x saturates
        send_word(command_word($urandom_range(1) ? 16'h7FFF : 16'h8000, 16'h0000,
                               16'($urandom)));
        repeat (LIMIT_TICKS)
            send_word(tick_word(16'hFFFF));

        // directed part at the power-up wheel base
        send_word(command_word(16'h0000, 16'h0000, 16'hFFFF));
        send_word(tick_word(16'hFFFF));
        send_word(command_word(16'd256, 16'h0000, 16'h0000));
        send_word(tick_word(16'd1));
        send_word(command_word(16'h0000, 16'd4096, 16'h0000));   // turn on the spot
        send_word(tick_word(16'hFFFF));
        send_word(command_word(16'h7FFF, 16'h7FFF, 16'h1234));
        send_word(tick_word(16'h0000));                          // empty tick
        send_word(tick_word(16'hFFFF));                          // heading wraps
        send_word(command_word(16'h8000, 16'h8000, 16'hFFFF));
        send_word(tick_word(16'h8000));
        send_word(command_word(16'h8000, 16'h7FFF, 16'h0000));
        send_word(tick_word(16'hFFFF));
        send_word(command_word(16'h7FFF, 16'h8000, 16'h0000));
        send_word(tick_word(16'hFFFF));
        send_word(command_word(16'h0001, 16'h7FFF, 16'h0000));   // steering near its limit
        send_word(tick_word(16'd1));
        send_word(command_word(16'hFFFF, 16'h7FFF, 16'h0000));
        send_word(tick_word(16'd12345));
        send_word(command_word(16'h0001, 16'h0001, 16'h0000));
        send_word(command_word(16'hFFFF, 16'hFFFF, 16'h0000));
        send_word(tick_word(16'h7FFF));
        send_word(command_word(16'd256, 16'd4096, 16'h0000));
        send_word(tick_word(16'hFFFF));

        run_phase(16'd1,          71, 0,  1'b0);
        run_phase(16'hFFFF,       0,  71, 1'b0);
        run_phase(16'd0,          30, 30, 1'b0);
        run_phase(16'($urandom),  0,  0,  1'b1);
        run_phase(16'd512,        30, 30, 1'b0);

        drain();
        if (sb.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* ackermann_pose_integrator.f */
rtl/api_pkg.sv
rtl/ackermann_pose_integrator.sv
tb/ackermann_pose_integrator_test.sv
